// File: rtl/ecu_pkg.sv
package ecu_pkg;

	// number format
	localparam int          FRAC_W  = 16;
	localparam logic [31:0] ONE     = 32'h0001_0000;
	localparam logic [31:0] HALF    = 32'h0000_8000;
	localparam logic [31:0] TWO     = 32'h0002_0000;
	localparam logic [31:0] THREE   = 32'h0003_0000;
	localparam logic [31:0] FOUR    = 32'h0004_0000;
	localparam logic [31:0] FIVE    = 32'h0005_0000;
	localparam logic [31:0] TEN     = 32'h000a_0000;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;

	// built-in back overshoots
	localparam logic [31:0] BACK_C    = 32'd111514;
	localparam logic [31:0] BACK_C_IO = 32'd99942;

	// exp underflow limit, -15.0
	localparam logic [31:0] EXP_FLOOR = 32'hfff1_0000;

	// reciprocal saturates when the divisor magnitude is at or below ONE >> 14
	localparam logic [31:0] DIV_SAT_LIM = 32'd4;

	// coarse log/exp step: 8.0, then halved per step
	localparam logic [31:0] STEP_BASE = 32'h0008_0000;

	localparam int COARSE_STEPS = 4;
	localparam int SHF_CELLS    = 20;
	localparam int DIV_CELLS    = 33;

	typedef enum logic [4:0] {
		ACT_LINEAR    = 5'd0,
		ACT_QUAD_IN   = 5'd1,
		ACT_QUAD_OUT  = 5'd2,
		ACT_QUAD_IO   = 5'd3,
		ACT_CUBIC_IN  = 5'd4,
		ACT_CUBIC_OUT = 5'd5,
		ACT_CUBIC_IO  = 5'd6,
		ACT_QUART_IN  = 5'd7,
		ACT_QUART_OUT = 5'd8,
		ACT_QUART_IO  = 5'd9,
		ACT_QUINT_IN  = 5'd10,
		ACT_QUINT_OUT = 5'd11,
		ACT_QUINT_IO  = 5'd12,
		ACT_EXPO_IN   = 5'd13,
		ACT_EXPO_OUT  = 5'd14,
		ACT_EXPO_IO   = 5'd15,
		ACT_BACK_IN   = 5'd16,
		ACT_BACK_OUT  = 5'd17,
		ACT_BACK_IO   = 5'd18,
		ACT_BACKP_IN  = 5'd19,
		ACT_BACKP_OUT = 5'd20,
		ACT_BACKP_IO  = 5'd21
	} act_t;

	// per-item data that rides along the cell chains
	typedef struct packed {
		act_t        act;
		logic [31:0] sv;
		logic [31:0] ev;
		logic [31:0] lo;
		logic [31:0] bq;
		logic [31:0] ex;
		logic        tlt;
		logic        tz;
		logic        tge;
		logic        lgneg;
		logic        lgdiv;
		logic        under;
		logic        eneg;
	} side_t;

	// restoring reciprocal lane
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] dsr;
		logic [31:0] opnd;
		logic        neg;
		side_t       side;
	} div_lane_t;

	// shift-and-add log/exp lane
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		side_t       side;
	} shf_lane_t;

	// 16.16 product, floor, wrapped to 32 bits
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		p = $signed(a) * $signed(b);
		return p[FRAC_W+31:FRAC_W];
	endfunction

	// log2(1 + 2^-(k+1)) in 16.16
	function automatic logic [31:0] ln_tab(input logic [3:0] k);
		logic [31:0] r;
		unique case (k)
			4'd0:  r = 32'h95c1;
			4'd1:  r = 32'h526a;
			4'd2:  r = 32'h2b80;
			4'd3:  r = 32'h1663;
			4'd4:  r = 32'h0b5d;
			4'd5:  r = 32'h05b9;
			4'd6:  r = 32'h02e0;
			4'd7:  r = 32'h0170;
			4'd8:  r = 32'h00b8;
			4'd9:  r = 32'h005c;
			4'd10: r = 32'h002e;
			4'd11: r = 32'h0017;
			4'd12: r = 32'h000b;
			4'd13: r = 32'h0006;
			4'd14: r = 32'h0003;
			4'd15: r = 32'h0001;
		endcase
		return r;
	endfunction

	// finish ONE / b from quotient magnitude, with saturation
	function automatic logic [31:0] recip_fix(input logic [31:0] q, input logic [31:0] dsr,
			input logic neg);
		logic [31:0] r;
		if (dsr <= DIV_SAT_LIM) begin
			r = neg ? S32_MIN : S32_MAX;
		end else begin
			r = neg ? (32'd0 - q) : q;
		end
		return r;
	endfunction

	// divide by two, toward zero
	function automatic logic [31:0] half_tz(input logic [31:0] v);
		logic [31:0] s;
		s = v + {31'd0, v[31]};
		return {s[31], s[31:1]};
	endfunction

	// 16.16 divide by 2.0, saturating at the most negative value
	function automatic logic [31:0] div2_sat(input logic [31:0] v);
		return (v == S32_MIN) ? S32_MIN : half_tz(v);
	endfunction

endpackage

// File: rtl/ecu_div_cell.sv
// One restoring step of 2^32 / dsr; the first cell takes the only set dividend bit.
module ecu_div_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  ecu_pkg::div_lane_t    din,
	output logic                  out_vld,
	output ecu_pkg::div_lane_t    dout
);

	localparam logic DBIT = (IDX == 0);

	logic [32:0] trial;
	logic [32:0] diff;
	logic        fit;

	// shift in next dividend bit, trial subtract
	assign trial = {din.rem, DBIT};
	assign diff  = trial - {1'b0, din.dsr};
	assign fit   = trial >= {1'b0, din.dsr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dout.rem  <= fit ? diff[31:0] : trial[31:0];
		dout.quo  <= {din.quo[30:0], fit};
		dout.dsr  <= din.dsr;
		dout.opnd <= din.opnd;
		dout.neg  <= din.neg;
		dout.side <= din.side;
	end

endmodule

// File: rtl/ecu_log_cell.sv
// One shift-and-add log2 step: coarse power-of-two scalings first, then table steps.
module ecu_log_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  ecu_pkg::shf_lane_t    din,
	output logic                  out_vld,
	output ecu_pkg::shf_lane_t    dout
);

	logic [31:0] trial;
	logic [31:0] inc;
	logic        take;

	generate
		if (IDX < ecu_pkg::COARSE_STEPS) begin : g_coarse
			assign trial = din.x << (8 >> IDX);
			assign inc   = ecu_pkg::STEP_BASE >> IDX;
		end else begin : g_fine
			assign trial = din.x + (din.x >> (IDX - ecu_pkg::COARSE_STEPS + 1));
			assign inc   = ecu_pkg::ln_tab(4'(IDX - ecu_pkg::COARSE_STEPS));
		end
	endgenerate

	assign take = $signed(trial) < $signed(ecu_pkg::ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dout.x    <= take ? trial : din.x;
		dout.y    <= take ? (din.y + inc) : din.y;
		dout.side <= din.side;
	end

endmodule

// File: rtl/ecu_exp_cell.sv
// One shift-and-add exp2 step: coarse powers first, then table steps.
module ecu_exp_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  ecu_pkg::shf_lane_t    din,
	output logic                  out_vld,
	output ecu_pkg::shf_lane_t    dout
);

	logic [31:0] trial;
	logic [31:0] ynext;
	logic        take;

	generate
		if (IDX < ecu_pkg::COARSE_STEPS) begin : g_coarse
			assign trial = din.x - (ecu_pkg::STEP_BASE >> IDX);
			assign ynext = din.y << (8 >> IDX);
		end else begin : g_fine
			assign trial = din.x - ecu_pkg::ln_tab(4'(IDX - ecu_pkg::COARSE_STEPS));
			assign ynext = din.y + (din.y >> (IDX - ecu_pkg::COARSE_STEPS + 1));
		end
	endgenerate

	assign take = !trial[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dout.x    <= take ? trial : din.x;
		dout.y    <= take ? ynext : din.y;
		dout.side <= din.side;
	end

endmodule

// File: rtl/fixed_point_easing_curve_unit.sv
// Channel   Handshake          Beat
// command   start / busy       action, progress, start_value, end_value, overshoot
// result    done (strobe)      eased_value
//
// Fully pipelined: one command beat per clock, busy stays low.
// Each result strobes done, in command order.
// Each command passes through the two 33-cell reciprocal chains and the two 20-cell
// log2/exp2 chains, plus sixteen setup, multiply and blend stages around them.
// Reset clears only the valid pipeline; the receiver cannot stall the result.
module fixed_point_easing_curve_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  action,
	input  logic [31:0] progress,
	input  logic [31:0] start_value,
	input  logic [31:0] end_value,
	input  logic [31:0] overshoot,
	output logic        done,
	output logic [31:0] eased_value
);

	localparam int DC = ecu_pkg::DIV_CELLS;
	localparam int SC = ecu_pkg::SHF_CELLS;

	// the pipeline never holds off a command
	assign busy = 1'b0;

	// ---------------- stage 1: capture command ----------------
	logic               v_s1;
	ecu_pkg::act_t      act_s1;
	logic [31:0]        t_s1, sv_s1, ev_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= ecu_pkg::act_t'(action);
		t_s1   <= progress;
		sv_s1  <= start_value;
		ev_s1  <= end_value;
		c_s1   <= overshoot;
	end

	// ---------------- stage 2: operand setup ----------------
	logic [31:0] cc_c, u_c, d_c, v_c, base_c, ex_c, t10_c, t20_c;
	logic        tlt_c;

	always_comb begin
		tlt_c = $signed(t_s1) < $signed(ecu_pkg::HALF);
		u_c   = t_s1 - ecu_pkg::ONE;
		d_c   = t_s1 << 1;
		t10_c = (t_s1 << 3) + (t_s1 << 1);
		t20_c = t10_c << 1;

		// overshoot source
		priority if (act_s1 == ecu_pkg::ACT_BACK_IN || act_s1 == ecu_pkg::ACT_BACK_OUT) begin
			cc_c = ecu_pkg::BACK_C;
		end else if (act_s1 == ecu_pkg::ACT_BACK_IO) begin
			cc_c = ecu_pkg::BACK_C_IO;
		end else begin
			cc_c = c_s1;
		end

		// back multiplier operand
		unique case (act_s1)
			ecu_pkg::ACT_BACK_OUT, ecu_pkg::ACT_BACKP_OUT: v_c = u_c;
			ecu_pkg::ACT_BACK_IO, ecu_pkg::ACT_BACKP_IO:
				v_c = tlt_c ? d_c : (d_c - ecu_pkg::TWO);
			default: v_c = t_s1;
		endcase

		// power base and exponent
		unique case (act_s1)
			ecu_pkg::ACT_QUAD_IO, ecu_pkg::ACT_CUBIC_IO,
			ecu_pkg::ACT_QUART_IO, ecu_pkg::ACT_QUINT_IO: base_c = ecu_pkg::TWO - d_c;
			ecu_pkg::ACT_CUBIC_OUT, ecu_pkg::ACT_QUART_OUT,
			ecu_pkg::ACT_QUINT_OUT: base_c = ecu_pkg::ONE - t_s1;
			ecu_pkg::ACT_EXPO_IN, ecu_pkg::ACT_EXPO_OUT,
			ecu_pkg::ACT_EXPO_IO: base_c = ecu_pkg::TWO;
			ecu_pkg::ACT_BACK_IO, ecu_pkg::ACT_BACKP_IO:
				base_c = tlt_c ? d_c : (ecu_pkg::TWO - d_c);
			default: base_c = ecu_pkg::ONE;
		endcase

		unique case (act_s1)
			ecu_pkg::ACT_QUAD_IO, ecu_pkg::ACT_BACK_IO,
			ecu_pkg::ACT_BACKP_IO: ex_c = ecu_pkg::TWO;
			ecu_pkg::ACT_CUBIC_OUT, ecu_pkg::ACT_CUBIC_IO: ex_c = ecu_pkg::THREE;
			ecu_pkg::ACT_QUART_OUT, ecu_pkg::ACT_QUART_IO: ex_c = ecu_pkg::FOUR;
			ecu_pkg::ACT_QUINT_OUT, ecu_pkg::ACT_QUINT_IO: ex_c = ecu_pkg::FIVE;
			ecu_pkg::ACT_EXPO_IN:  ex_c = t10_c - ecu_pkg::TEN;
			ecu_pkg::ACT_EXPO_OUT: ex_c = 32'd0 - t10_c;
			ecu_pkg::ACT_EXPO_IO:
				ex_c = tlt_c ? (t20_c - ecu_pkg::TEN) : (ecu_pkg::TEN - t20_c);
			default: ex_c = 32'd0;
		endcase
	end

	logic               v_s2;
	ecu_pkg::act_t      act_s2;
	logic [31:0]        t_s2, sv_s2, ev_s2, cc_s2, cq1_s2, u_s2, v_s2x, base_s2, ex_s2;
	logic               tlt_s2, tz_s2, tge_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s2  <= act_s1;
		t_s2    <= t_s1;
		sv_s2   <= sv_s1;
		ev_s2   <= ev_s1;
		cc_s2   <= cc_c;
		cq1_s2  <= cc_c + ecu_pkg::ONE;
		u_s2    <= u_c;
		v_s2x   <= v_c;
		base_s2 <= base_c;
		ex_s2   <= ex_c;
		tlt_s2  <= tlt_c;
		tz_s2   <= (t_s1 == 32'd0);
		tge_s2  <= $signed(t_s1) >= $signed(ecu_pkg::ONE);
	end

	// ---------------- stage 3: t^2, u^2, back product ----------------
	logic               v_s3;
	ecu_pkg::act_t      act_s3;
	logic [31:0]        t_s3, sv_s3, ev_s3, cc_s3, base_s3, ex_s3, t2_s3, uu_s3, bm_s3;
	logic               tlt_s3, tz_s3, tge_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		act_s3  <= act_s2;
		t_s3    <= t_s2;
		sv_s3   <= sv_s2;
		ev_s3   <= ev_s2;
		cc_s3   <= cc_s2;
		base_s3 <= base_s2;
		ex_s3   <= ex_s2;
		tlt_s3  <= tlt_s2;
		tz_s3   <= tz_s2;
		tge_s3  <= tge_s2;
		t2_s3   <= ecu_pkg::fmul(t_s2, t_s2);
		uu_s3   <= ecu_pkg::fmul(u_s2, u_s2);
		bm_s3   <= ecu_pkg::fmul(cq1_s2, v_s2x);
	end

	// ---------------- stage 4: t^3, t^4, back polynomial term ----------------
	logic bsub_c, bin_s3c;

	assign bin_s3c = (act_s3 == ecu_pkg::ACT_BACK_IN) || (act_s3 == ecu_pkg::ACT_BACKP_IN);
	assign bsub_c  = bin_s3c || (((act_s3 == ecu_pkg::ACT_BACK_IO) ||
		(act_s3 == ecu_pkg::ACT_BACKP_IO)) && tlt_s3);

	logic               v_s4;
	ecu_pkg::act_t      act_s4;
	logic [31:0]        t_s4, sv_s4, ev_s4, base_s4, ex_s4, t2_s4, t3_s4, t4_s4, uu_s4, bq_s4;
	logic               tlt_s4, tz_s4, tge_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		act_s4  <= act_s3;
		t_s4    <= t_s3;
		sv_s4   <= sv_s3;
		ev_s4   <= ev_s3;
		base_s4 <= base_s3;
		ex_s4   <= ex_s3;
		tlt_s4  <= tlt_s3;
		tz_s4   <= tz_s3;
		tge_s4  <= tge_s3;
		t2_s4   <= t2_s3;
		uu_s4   <= uu_s3;
		t3_s4   <= ecu_pkg::fmul(t_s3, t2_s3);
		t4_s4   <= ecu_pkg::fmul(t2_s3, t2_s3);
		bq_s4   <= bsub_c ? (bm_s3 - cc_s3) : (bm_s3 + cc_s3);
	end

	// ---------------- stage 5: t^5, back in/out product ----------------
	logic bin_s4c;

	assign bin_s4c = (act_s4 == ecu_pkg::ACT_BACK_IN) || (act_s4 == ecu_pkg::ACT_BACKP_IN);

	logic               v_s5;
	ecu_pkg::act_t      act_s5;
	logic [31:0]        t_s5, sv_s5, ev_s5, base_s5, ex_s5, t2_s5, t3_s5, t4_s5, t5_s5;
	logic [31:0]        uu_s5, bq_s5, bp_s5;
	logic               tlt_s5, tz_s5, tge_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		act_s5  <= act_s4;
		t_s5    <= t_s4;
		sv_s5   <= sv_s4;
		ev_s5   <= ev_s4;
		base_s5 <= base_s4;
		ex_s5   <= ex_s4;
		tlt_s5  <= tlt_s4;
		tz_s5   <= tz_s4;
		tge_s5  <= tge_s4;
		t2_s5   <= t2_s4;
		t3_s5   <= t3_s4;
		t4_s5   <= t4_s4;
		uu_s5   <= uu_s4;
		bq_s5   <= bq_s4;
		t5_s5   <= ecu_pkg::fmul(t_s4, t4_s4);
		bp_s5   <= ecu_pkg::fmul(bin_s4c ? t2_s4 : uu_s4, bq_s4);
	end

	// ---------------- stage 6: direct curves, launch log reciprocal ----------------
	logic [31:0] lo_c;

	always_comb begin
		unique case (act_s5)
			ecu_pkg::ACT_LINEAR:   lo_c = t_s5;
			ecu_pkg::ACT_QUAD_IN:  lo_c = t2_s5;
			ecu_pkg::ACT_QUAD_OUT: lo_c = ecu_pkg::ONE - uu_s5;
			ecu_pkg::ACT_QUAD_IO:  lo_c = t2_s5 << 1;
			ecu_pkg::ACT_CUBIC_IN: lo_c = t3_s5;
			ecu_pkg::ACT_CUBIC_IO: lo_c = t3_s5 << 2;
			ecu_pkg::ACT_QUART_IN: lo_c = t4_s5;
			ecu_pkg::ACT_QUART_IO: lo_c = t4_s5 << 3;
			ecu_pkg::ACT_QUINT_IN: lo_c = t5_s5;
			ecu_pkg::ACT_QUINT_IO: lo_c = t5_s5 << 4;
			ecu_pkg::ACT_BACK_IN, ecu_pkg::ACT_BACKP_IN: lo_c = bp_s5;
			ecu_pkg::ACT_BACK_OUT, ecu_pkg::ACT_BACKP_OUT: lo_c = ecu_pkg::ONE + bp_s5;
			default: lo_c = 32'd0;
		endcase
	end

	ecu_pkg::div_lane_t da [0:DC];
	logic               dav [0:DC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dav[0] <= 1'b0;
		end else begin
			dav[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		da[0].rem        <= 32'd0;
		da[0].quo        <= 32'd0;
		da[0].dsr        <= base_s5[31] ? (32'd0 - base_s5) : base_s5;
		da[0].opnd       <= base_s5;
		da[0].neg        <= base_s5[31];
		da[0].side.act   <= act_s5;
		da[0].side.sv    <= sv_s5;
		da[0].side.ev    <= ev_s5;
		da[0].side.lo    <= lo_c;
		da[0].side.bq    <= bq_s5;
		da[0].side.ex    <= ex_s5;
		da[0].side.tlt   <= tlt_s5;
		da[0].side.tz    <= tz_s5;
		da[0].side.tge   <= tge_s5;
		da[0].side.lgneg <= $signed(base_s5) <= $signed(ecu_pkg::ONE);
		da[0].side.lgdiv <= base_s5 > ecu_pkg::ONE;
		da[0].side.under <= 1'b0;
		da[0].side.eneg  <= 1'b0;
	end

	// reciprocal chain for log arguments above 1.0
	generate
		for (genvar i = 0; i < DC; i++) begin : g_div_a
			ecu_div_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.in_vld  (dav[i]),
				.din     (da[i]),
				.out_vld (dav[i+1]),
				.dout    (da[i+1])
			);
		end
	endgenerate

	// ---------------- log chain ----------------
	ecu_pkg::shf_lane_t la [0:SC];
	logic               lav [0:SC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lav[0] <= 1'b0;
		end else begin
			lav[0] <= dav[DC];
		end
	end

	always_ff @(posedge clk) begin
		la[0].x    <= da[DC].side.lgdiv ?
			ecu_pkg::recip_fix(da[DC].quo, da[DC].dsr, da[DC].neg) : da[DC].opnd;
		la[0].y    <= 32'd0;
		la[0].side <= da[DC].side;
	end

	generate
		for (genvar i = 0; i < SC; i++) begin : g_log
			ecu_log_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.in_vld  (lav[i]),
				.din     (la[i]),
				.out_vld (lav[i+1]),
				.dout    (la[i+1])
			);
		end
	endgenerate

	// log sign, then exponent product
	logic               v_lb, v_lc;
	logic [31:0]        lg_lb, arg_lc;
	ecu_pkg::side_t     sd_lb, sd_lc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_lb <= 1'b0;
			v_lc <= 1'b0;
		end else begin
			v_lb <= lav[SC];
			v_lc <= v_lb;
		end
	end

	always_ff @(posedge clk) begin
		lg_lb  <= la[SC].side.lgneg ? (32'd0 - la[SC].y) : la[SC].y;
		sd_lb  <= la[SC].side;
		arg_lc <= ecu_pkg::fmul(sd_lb.ex, lg_lb);
		sd_lc  <= sd_lb;
	end

	// ---------------- exp chain ----------------
	ecu_pkg::shf_lane_t ea [0:SC];
	logic               eav [0:SC];
	ecu_pkg::side_t     sd_e_c;

	// underflow and sign flags join the side data
	always_comb begin
		sd_e_c       = sd_lc;
		sd_e_c.under = $signed(arg_lc) <= $signed(ecu_pkg::EXP_FLOOR);
		sd_e_c.eneg  = arg_lc[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eav[0] <= 1'b0;
		end else begin
			eav[0] <= v_lc;
		end
	end

	always_ff @(posedge clk) begin
		ea[0].x    <= arg_lc[31] ? (32'd0 - arg_lc) : arg_lc;
		ea[0].y    <= ecu_pkg::ONE;
		ea[0].side <= sd_e_c;
	end

	generate
		for (genvar i = 0; i < SC; i++) begin : g_exp
			ecu_exp_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.in_vld  (eav[i]),
				.din     (ea[i]),
				.out_vld (eav[i+1]),
				.dout    (ea[i+1])
			);
		end
	endgenerate

	// reciprocal chain for negative exponents
	ecu_pkg::div_lane_t db [0:DC];
	logic               dbv [0:DC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbv[0] <= 1'b0;
		end else begin
			dbv[0] <= eav[SC];
		end
	end

	always_ff @(posedge clk) begin
		db[0].rem  <= 32'd0;
		db[0].quo  <= 32'd0;
		db[0].dsr  <= ea[SC].y[31] ? (32'd0 - ea[SC].y) : ea[SC].y;
		db[0].opnd <= ea[SC].y;
		db[0].neg  <= ea[SC].y[31];
		db[0].side <= ea[SC].side;
	end

	generate
		for (genvar i = 0; i < DC; i++) begin : g_div_b
			ecu_div_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.in_vld  (dbv[i]),
				.din     (db[i]),
				.out_vld (dbv[i+1]),
				.dout    (db[i+1])
			);
		end
	endgenerate

	// ---------------- back end ----------------
	logic               v_p0, v_p1, v_p2, v_p3;
	logic [31:0]        pw_p0, pw_p1, pq_p1, x_p2, ps_p3, pe_p3, sum_c;
	ecu_pkg::side_t     sd_p0, sd_p1;
	logic               nul_p2, nul_p3;
	logic [31:0]        sv_p2, ev_p2;
	logic [31:0]        x_c;
	logic               done_q;
	logic [31:0]        eased_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p0   <= 1'b0;
			v_p1   <= 1'b0;
			v_p2   <= 1'b0;
			v_p3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_p0   <= dbv[DC];
			v_p1   <= v_p0;
			v_p2   <= v_p1;
			v_p3   <= v_p2;
			done_q <= v_p3;
		end
	end

	// eased fraction by curve
	always_comb begin
		unique case (sd_p1.act)
			ecu_pkg::ACT_QUAD_IO, ecu_pkg::ACT_CUBIC_IO,
			ecu_pkg::ACT_QUART_IO, ecu_pkg::ACT_QUINT_IO:
				x_c = sd_p1.tlt ? sd_p1.lo : (ecu_pkg::ONE - ecu_pkg::half_tz(pw_p1));
			ecu_pkg::ACT_CUBIC_OUT, ecu_pkg::ACT_QUART_OUT,
			ecu_pkg::ACT_QUINT_OUT: x_c = ecu_pkg::ONE - pw_p1;
			ecu_pkg::ACT_EXPO_IN: x_c = sd_p1.tz ? 32'd0 : pw_p1;
			ecu_pkg::ACT_EXPO_OUT: x_c = sd_p1.tge ? ecu_pkg::ONE : (ecu_pkg::ONE - pw_p1);
			ecu_pkg::ACT_EXPO_IO: begin
				priority if (sd_p1.tz) begin
					x_c = 32'd0;
				end else if (sd_p1.tge) begin
					x_c = ecu_pkg::ONE;
				end else if (sd_p1.tlt) begin
					x_c = ecu_pkg::div2_sat(pw_p1);
				end else begin
					x_c = ecu_pkg::div2_sat(ecu_pkg::TWO - pw_p1);
				end
			end
			ecu_pkg::ACT_BACK_IO, ecu_pkg::ACT_BACKP_IO:
				x_c = ecu_pkg::half_tz(sd_p1.tlt ? pq_p1 : (pq_p1 + ecu_pkg::TWO));
			default: x_c = sd_p1.lo;
		endcase
	end

	assign sum_c = ps_p3 + pe_p3;

	always_ff @(posedge clk) begin
		// power result: underflow, reciprocal, or direct
		pw_p0   <= db[DC].side.under ? 32'd0 :
			(db[DC].side.eneg ? ecu_pkg::recip_fix(db[DC].quo, db[DC].dsr, db[DC].neg)
				: db[DC].opnd);
		sd_p0   <= db[DC].side;
		pw_p1   <= pw_p0;
		pq_p1   <= ecu_pkg::fmul(pw_p0, sd_p0.bq);
		sd_p1   <= sd_p0;
		x_p2    <= x_c;
		sv_p2   <= sd_p1.sv;
		ev_p2   <= sd_p1.ev;
		nul_p2  <= sd_p1.act > ecu_pkg::ACT_BACKP_IO;
		ps_p3   <= ecu_pkg::fmul(ecu_pkg::ONE - x_p2, sv_p2);
		pe_p3   <= ecu_pkg::fmul(x_p2, ev_p2);
		nul_p3  <= nul_p2;
		eased_q <= nul_p3 ? 32'd0 : sum_c;
	end

	assign done        = done_q;
	assign eased_value = eased_q;

endmodule
